/* rtl/stu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_pkg
// Shared types, codes and helpers of the source text tokenizer.
// ----------------------------------------------------------------------------
package stu_pkg;

    localparam int POS_WIDTH   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [POS_WIDTH-1:0] t_pos;
    localparam t_pos POS_MAX = '1;

    localparam logic [2:0] KIND_ASSIGN  = 3'd0;
    localparam logic [2:0] KIND_LET     = 3'd1;
    localparam logic [2:0] KIND_IDENT   = 3'd2;
    localparam logic [2:0] KIND_INTEGER = 3'd3;
    localparam logic [2:0] KIND_DECIMAL = 3'd4;
    localparam logic [2:0] KIND_ILLEGAL = 3'd5;

    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_L    = 3'd1;
    localparam logic [2:0] KW_LE   = 3'd2;
    localparam logic [2:0] KW_LET  = 3'd3;
    localparam logic [2:0] KW_MISS = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_T     = 8'h74;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_IDENT = 3'b010,
        MODE_NUM   = 3'b100
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic [31:0] token_line;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        t_token rec0;
        t_token rec1;
        logic   two;
    } t_bundle;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic t_pos sat_inc(input t_pos v);
        return (v == POS_MAX) ? POS_MAX : v + t_pos'(1);
    endfunction

    function automatic t_token make_token(input logic [2:0] kind, input t_pos start,
                                          input t_pos len, input t_pos line);
        logic [63:0] s64;
        logic [63:0] l64;
        logic [63:0] n64;
        t_token      t;
        s64 = 64'(start);
        l64 = 64'(len);
        n64 = 64'(line);
        t.token_kind   = kind;
        t.token_start  = s64[31:0];
        t.token_length = (l64 > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : l64[31:0];
        t.token_line   = n64[31:0];
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    function automatic logic [2:0] open_kind(input t_mode mode, input logic [2:0] kw,
                                             input logic dot);
        logic [2:0] k;
        k = KIND_IDENT;
        unique case (mode)
            MODE_IDENT: k = (kw == KW_LET) ? KIND_LET : KIND_IDENT;
            MODE_NUM:   k = dot ? KIND_DECIMAL : KIND_INTEGER;
            default:    k = KIND_IDENT;
        endcase
        return k;
    endfunction

endpackage

/* rtl/stu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_front
// Scanner front end: classifies each byte, tracks the open token and
// position counters, and forms the bundle of records the byte produces.
// ----------------------------------------------------------------------------
module stu_front import stu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  logic     i_full,
    input  t_in_item i_item,
    output logic     o_wr,
    output t_bundle  o_bundle
);

    t_mode      r_mode,   n_mode;
    t_pos       r_pos,    n_pos;
    t_pos       r_line,   n_line;
    t_pos       r_anchor, n_anchor;
    logic       r_dot,    n_dot;
    logic [2:0] r_kw,     n_kw;
    logic       r_ended,  n_ended;

    logic       accept;
    logic [7:0] c;
    logic       c_alpha, c_digit, c_ws, cont;
    logic       a_v, b_v, l_v;
    logic [2:0] b_kind;
    t_token     a_tok, b_tok, l_tok;
    t_bundle    bnd;

    assign accept  = i_push && !i_full;
    assign c       = i_item.ch;
    assign c_alpha = is_alpha(c);
    assign c_digit = is_digit(c);
    assign c_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_line   = r_line;
        n_anchor = r_anchor;
        n_dot    = r_dot;
        n_kw     = r_kw;
        n_ended  = r_ended;
        a_v      = 1'b0;
        b_v      = 1'b0;
        l_v      = 1'b0;
        b_kind   = KIND_ILLEGAL;
        cont     = ((r_mode == MODE_IDENT) && (c_alpha || c_digit)) ||
                   ((r_mode == MODE_NUM) &&
                    (c_digit || c == CH_UNDER || (c == CH_DOT && !r_dot)));
        a_tok    = make_token(open_kind(r_mode, r_kw, r_dot), r_anchor,
                              r_pos - r_anchor, r_line);
        if (r_ended) begin
            n_ended = r_ended;
        end else if (c == CH_NUL) begin
            a_v     = (r_mode != MODE_IDLE);
            n_mode  = MODE_IDLE;
            n_dot   = 1'b0;
            n_kw    = KW_NONE;
            n_ended = 1'b1;
        end else begin
            n_pos = sat_inc(r_pos);
            if (cont) begin
                if (r_mode == MODE_IDENT) begin
                    if (r_kw == KW_L && c == CH_E) begin
                        n_kw = KW_LE;
                    end else if (r_kw == KW_LE && c == CH_T) begin
                        n_kw = KW_LET;
                    end else begin
                        n_kw = KW_MISS;
                    end
                end else if (c == CH_DOT) begin
                    n_dot = 1'b1;
                end
            end else begin
                a_v    = (r_mode != MODE_IDLE);
                n_mode = MODE_IDLE;
                n_dot  = 1'b0;
                n_kw   = KW_NONE;
                if (c == CH_NL) begin
                    n_line = sat_inc(r_line);
                end else if (c == CH_EQ) begin
                    b_v    = 1'b1;
                    b_kind = KIND_ASSIGN;
                end else if (c_alpha) begin
                    n_mode   = MODE_IDENT;
                    n_anchor = r_pos;
                    n_kw     = (c == CH_L) ? KW_L : KW_MISS;
                end else if (c_digit) begin
                    n_mode   = MODE_NUM;
                    n_anchor = r_pos;
                end else if (!c_ws) begin
                    b_v    = 1'b1;
                    b_kind = KIND_ILLEGAL;
                end
            end
            l_v = i_item.last_byte && (n_mode != MODE_IDLE);
        end
        b_tok = make_token(b_kind, r_pos, t_pos'(1), r_line);
        l_tok = make_token(open_kind(n_mode, n_kw, n_dot), n_anchor,
                           n_pos - n_anchor, n_line);
        if (i_item.last_byte) begin
            n_mode   = MODE_IDLE;
            n_pos    = '0;
            n_line   = '0;
            n_anchor = '0;
            n_dot    = 1'b0;
            n_kw     = KW_NONE;
            n_ended  = 1'b0;
        end
    end

    always_comb begin
        bnd = '0;
        if (a_v) begin
            bnd.rec0 = a_tok;
            bnd.rec1 = b_v ? b_tok : l_tok;
            bnd.two  = b_v || l_v;
        end else if (b_v) begin
            bnd.rec0 = b_tok;
            bnd.rec1 = l_tok;
            bnd.two  = l_v;
        end else begin
            bnd.rec0 = l_tok;
            bnd.rec1 = l_tok;
            bnd.two  = 1'b0;
        end
        bnd.rec0.last_of_run = !bnd.two;
        bnd.rec1.last_of_run = 1'b1;
    end

    assign o_wr     = accept && (a_v || b_v || l_v);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_line   <= '0;
            r_anchor <= '0;
            r_dot    <= 1'b0;
            r_kw     <= KW_NONE;
            r_ended  <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_anchor <= n_anchor;
            r_dot    <= n_dot;
            r_kw     <= n_kw;
            r_ended  <= n_ended;
        end
    end

endmodule

/* rtl/stu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_queue
// Short FIFO of record bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
module stu_queue import stu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_wr_data,
    input  logic    i_rd,
    output logic    o_full,
    output logic    o_empty,
    output t_bundle o_rd_data
);

    t_bundle             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_wr, do_rd;

    assign o_full    = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_rd) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

/* rtl/stu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_back
// Output stage: unpacks bundles into single records and holds the current
// record in an output register until it is popped.
// ----------------------------------------------------------------------------
module stu_back import stu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_bundle i_q_data,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_token  o_result
);

    logic   r_valid;
    logic   r_sel;
    t_token r_out;
    logic   load, take;

    assign load     = !r_valid || i_pop;
    assign take     = load && !i_q_empty;
    assign o_q_rd   = take && (r_sel || !i_q_data.two);
    assign o_empty  = !r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            if (take) begin
                r_sel <= !r_sel && i_q_data.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_sel ? i_q_data.rec1 : i_q_data.rec0;
        end
    end

endmodule

/* rtl/source_text_tokenizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Streaming lexer: source bytes in, token records out.
//
// Input side is a queue write port: drive i_item and raise push; a byte is
// taken on a rising edge with push high and full low. Result side is a queue
// read port: while empty is low, o_result holds the oldest token record and
// pop takes it.
// Each byte is scanned in the cycle it is accepted, so one byte is taken per
// cycle while the result side keeps up. A byte yields zero, one or two
// records; each is written to the queue, then loaded into the output
// register before it shows on o_result. While pop is high the output stage
// drains one record per cycle; the four-bundle queue absorbs two-record bytes.
// When pop stays low the queue fills and full rises; no beat is lost.
// Reset clears the scanner state, position and line counters and the queue;
// empty is high and full is low after reset.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit import stu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     empty,
    input  logic     pop,
    output t_token   o_result
);

    logic    fe_wr;
    t_bundle fe_bundle;
    logic    q_empty;
    logic    q_rd;
    t_bundle q_data;

    stu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_full   (full),
        .i_item   (i_item),
        .o_wr     (fe_wr),
        .o_bundle (fe_bundle)
    );

    stu_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (fe_wr),
        .i_wr_data (fe_bundle),
        .i_rd      (q_rd),
        .o_full    (full),
        .o_empty   (q_empty),
        .o_rd_data (q_data)
    );

    stu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.token_kind <= KIND_ILLEGAL)
        else $error("token kind out of range");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.token_length != 32'd0)
        else $error("zero length token");

    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result.token_kind == KIND_ASSIGN ||
                   o_result.token_kind == KIND_ILLEGAL)
        |-> o_result.token_length == 32'd1)
        else $error("single byte token with wrong length");

endmodule
